>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for concurrent checks clocked on a rising edge, with a
// synchronous active-low reset disabling them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hw/rtl/m9s_pkg.sv
// ----------------------------------------------------------------------------
// m9s_pkg
// Shared types, constants and the segment decoder of the median meter.
// ----------------------------------------------------------------------------
package m9s_pkg;

    // window and field widths
    localparam int WINDOW   = 9;
    localparam int SAMPLE_W = 10;
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int MED_IDX  = WINDOW / 2;
    localparam int SEG_W    = 7;
    localparam int VAL_W    = 13;
    localparam int VOLT_W   = 12;
    localparam int GAIN_W   = 5;
    localparam int OFS_W    = 4;

    // divide by ten: q = (x * 52429) >> 19, exact for x below 81920
    localparam logic [15:0] DIV10_MUL = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    // configuration register indexes
    localparam logic [1:0] CFG_VOLT_GAIN = 2'd0;
    localparam logic [1:0] CFG_CURR_GAIN = 2'd1;
    localparam logic [1:0] CFG_CURR_OFS  = 2'd2;

    // register reset values
    localparam logic [GAIN_W-1:0] VOLT_GAIN_RST = 5'd16;
    localparam logic [GAIN_W-1:0] CURR_GAIN_RST = 5'd15;
    localparam logic [OFS_W-1:0]  CURR_OFS_RST  = 4'd2;

    // segment patterns, digits 0..9
    localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
        7'h77, 7'h44, 7'h5B, 7'h5E, 7'h6C, 7'h3E, 7'h3F, 7'h54, 7'h7F, 7'h7E
    };

    typedef struct packed {
        logic [GAIN_W-1:0] voltage_gain_tenths;
        logic [GAIN_W-1:0] current_gain_tenths;
        logic [OFS_W-1:0]  current_offset;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median;
        logic                full;
        logic [FILL_W-1:0]   fill;
    } chain_stat_t;

    // negative nonzero digit and anything above nine show the eight
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d, input logic neg);
        logic [SEG_W-1:0] s;
        if ((neg && d != 4'd0) || d > 4'd9) begin
            s = SEG_CODE[8];
        end else begin
            s = SEG_CODE[d];
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/m9s_cell.sv
// ----------------------------------------------------------------------------
// m9s_cell
// One place of the sorted sample chain: keeps its value, takes the new
// sample or its left neighbour's value when an insert passes it.
// ----------------------------------------------------------------------------
module m9s_cell import m9s_pkg::*; (
    input  logic                aclk,
    input  logic                insert,
    input  logic                occupied,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] left_value,
    input  logic                left_gt,
    output logic [SAMPLE_W-1:0] value,
    output logic                gt
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;

    // empty place or larger value: the new sample lands here or to the left
    assign gt = !occupied || (value_reg > sample);

    always_comb begin
        value_next = value_reg;
        if (insert && gt) begin
            value_next = left_gt ? left_value : sample;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> hw/rtl/m9s_chain.sv
// ----------------------------------------------------------------------------
// m9s_chain
// Insertion-sort chain of WINDOW cells with the fill count; the middle
// cell holds the median once the window is full.
// ----------------------------------------------------------------------------
module m9s_chain import m9s_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  logic [SAMPLE_W-1:0] sample,
    output chain_stat_t         stat
);

    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic                full;
    logic                insert;
    logic [SAMPLE_W-1:0] cell_value [WINDOW];
    logic                cell_gt    [WINDOW];

    assign full   = (fill_reg == FILL_W'(WINDOW));
    assign insert = in_accept && !full;

    // row of cells, each fed by its left neighbour
    genvar i;
    generate
        for (i = 0; i < WINDOW; i++) begin : g_cell
            if (i == 0) begin : g_first
                m9s_cell u_cell (
                    .aclk       (aclk),
                    .insert     (insert),
                    .occupied   (FILL_W'(i) < fill_reg),
                    .sample     (sample),
                    .left_value ({SAMPLE_W{1'b0}}),
                    .left_gt    (1'b0),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i])
                );
            end else begin : g_rest
                m9s_cell u_cell (
                    .aclk       (aclk),
                    .insert     (insert),
                    .occupied   (FILL_W'(i) < fill_reg),
                    .sample     (sample),
                    .left_value (cell_value[i-1]),
                    .left_gt    (cell_gt[i-1]),
                    .value      (cell_value[i]),
                    .gt         (cell_gt[i])
                );
            end
        end
    endgenerate

    // count up on a stored sample, back to empty on the median beat
    always_comb begin
        fill_next = fill_reg;
        if (in_accept) begin
            fill_next = full ? '0 : fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign stat.median = cell_value[MED_IDX];
    assign stat.full   = full;
    assign stat.fill   = fill_reg;

endmodule

>>> hw/rtl/m9s_readout.sv
// ----------------------------------------------------------------------------
// m9s_readout
// Sequencer that scales the median into the held readings, splits the
// shown reading into decimal digits and holds the result beat.
// ----------------------------------------------------------------------------
module m9s_readout import m9s_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic          in_measure_current,
    input  chain_stat_t   chain_st,
    input  cfg_t          cfg,
    output logic          in_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,
    output logic          m_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_QUOT  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIG   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    cur_reg;
    logic                    fresh_reg;
    logic [14:0]             mag_reg;
    logic                    neg_reg;
    logic [VOLT_W-1:0]       volt_reading_reg;
    logic signed [VAL_W-1:0] curr_reading_reg;
    logic signed [VAL_W-1:0] shown_reg;
    logic                    dig_neg_reg;
    logic [VAL_W-1:0]        dig_x_reg;
    logic [1:0]              step_reg;
    logic [SEG_W-1:0]        seg_reg [4];
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    logic [14:0]             prod;
    logic [7:0]              ofs10;
    logic signed [15:0]      scaled;
    logic [14:0]             div_in;
    logic [30:0]             div_prod;
    logic [11:0]             div_q;
    logic [VAL_W-1:0]        q_ext;
    logic [VAL_W-1:0]        q10;
    logic [VAL_W-1:0]        rem;
    logic signed [VAL_W-1:0] shown;
    logic                    out_free;

    // median times gain, less ten times the offset in current mode
    assign prod   = 15'(chain_st.median) * 15'(cfg.voltage_gain_tenths & {GAIN_W{!cur_reg}}
                    | cfg.current_gain_tenths & {GAIN_W{cur_reg}});
    assign ofs10  = 8'({cfg.current_offset, 3'b000}) + 8'({cfg.current_offset, 1'b0});
    assign scaled = cur_reg ? ($signed({1'b0, prod}) - $signed({8'b0, ofs10}))
                            : $signed({1'b0, prod});

    // shared divide-by-ten unit
    assign div_in   = (state_reg == ST_QUOT) ? mag_reg : 15'(dig_x_reg);
    assign div_prod = 31'(div_in) * 31'(DIV10_MUL);
    assign div_q    = div_prod[30:DIV10_SHIFT];
    assign q_ext    = VAL_W'(div_q);
    assign q10      = VAL_W'({div_q, 3'b000}) + VAL_W'({div_q, 1'b0});
    assign rem      = dig_x_reg - q10;

    assign shown    = cur_reg ? curr_reading_reg : $signed({1'b0, volt_reading_reg});
    assign out_free = !m_tvalid_reg || m_tready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) begin
                state_next = chain_st.full ? ST_SCALE : ST_LOAD;
            end
            ST_SCALE: state_next = ST_QUOT;
            ST_QUOT:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIG;
            ST_DIG:   if (step_reg == 2'd2) begin
                state_next = ST_OUT;
            end
            ST_OUT:   if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            volt_reading_reg <= '0;
            curr_reading_reg <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            // readings update from the quotient of the scaled median
            if (state_reg == ST_QUOT) begin
                if (cur_reg) begin
                    curr_reading_reg <= neg_reg ? -$signed(q_ext) : $signed(q_ext);
                end else begin
                    volt_reading_reg <= div_q;
                end
            end
            // result register
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && in_accept) begin
            cur_reg   <= in_measure_current;
            fresh_reg <= chain_st.full;
        end
        if (state_reg == ST_SCALE) begin
            neg_reg <= scaled[15];
            mag_reg <= scaled[15] ? 15'(-scaled) : scaled[14:0];
        end
        if (state_reg == ST_LOAD) begin
            shown_reg   <= shown;
            dig_neg_reg <= shown[VAL_W-1];
            dig_x_reg   <= shown[VAL_W-1] ? VAL_W'(-shown) : shown;
            step_reg    <= 2'd0;
        end
        // one decimal digit a cycle; the last quotient is the thousands digit
        if (state_reg == ST_DIG) begin
            seg_reg[step_reg] <= seg_of(rem[3:0], dig_neg_reg);
            dig_x_reg         <= q_ext;
            step_reg          <= step_reg + 1'b1;
            if (step_reg == 2'd2) begin
                seg_reg[3] <= seg_of(div_q[3:0], dig_neg_reg);
            end
        end
        if (state_reg == ST_OUT && out_free) begin
            m_tdata_reg <= {7'b0, shown_reg, seg_reg[3], seg_reg[2], seg_reg[1], seg_reg[0]};
            m_tuser_reg <= fresh_reg;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> hw/rtl/median9_meter_to_seven_segment.sv
// ----------------------------------------------------------------------------
// median9_meter_to_seven_segment
// Median-of-nine meter with a four-digit seven-segment readout.
// Input beats carry a 10-bit converter sample in s_tdata and the mode
// (0 voltage, 1 current) in s_tuser. Nine beats fill the sorted window;
// the tenth beat drops its sample, scales the median into the reading of
// its mode and empties the window. Every input beat yields one output beat
// with the four digit codes and the held reading of that mode; m_tuser
// flags a freshly computed reading.
// Timing: one beat at a time. A storing beat passes the load, digit and
// output states; a median beat first scales and divides by ten, then goes
// the same way, one digit per cycle through the shared divide-by-ten
// multiplier. The next beat is taken as soon as the result sits in the
// output register.
// Reset empties the window and zeroes both readings; the gain and offset
// registers return to 1.6, 1.5 and 2. A stalled receiver holds the result
// beat; the sequencer still takes one new beat, then waits in its output
// state with that result until the held one is handed over.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module median9_meter_to_seven_segment import m9s_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_addr,
    input  logic [4:0]  cfg_wr_data,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample
    input  logic        s_tuser,   // [0] measure_current
    // readout stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] seg_ones, [13:7] seg_tens, [20:14] seg_hundreds,
                                   // [27:21] seg_thousands, [40:28] shown_value
    output logic        m_tuser    // [0] new_reading
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    chain_stat_t chain_st;
    logic        in_accept;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_addr)
                CFG_VOLT_GAIN: cfg_next.voltage_gain_tenths = cfg_wr_data[GAIN_W-1:0];
                CFG_CURR_GAIN: cfg_next.current_gain_tenths = cfg_wr_data[GAIN_W-1:0];
                CFG_CURR_OFS:  cfg_next.current_offset      = cfg_wr_data[OFS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.voltage_gain_tenths <= VOLT_GAIN_RST;
            cfg_reg.current_gain_tenths <= CURR_GAIN_RST;
            cfg_reg.current_offset      <= CURR_OFS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_accept = s_tvalid && s_tready;

    m9s_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .stat      (chain_st)
    );

    m9s_readout u_readout (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .in_accept          (in_accept),
        .in_measure_current (s_tuser),
        .chain_st           (chain_st),
        .cfg                (cfg_reg),
        .in_ready           (s_tready),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser)
    );

    // checks
    `ASSERT_NEXT(a_fill_clear, aclk, aresetn, in_accept && chain_st.full, chain_st.fill == '0)
    `ASSERT_NEXT(a_fill_step, aclk, aresetn, in_accept && !chain_st.full,
                 chain_st.fill == $past(chain_st.fill) + 1'b1)
    `ASSERT_IMP(a_out_after_busy, aclk, aresetn, $rose(m_tvalid), !$past(s_tready))

endmodule
